// ===== rtl/core/pjb_pkg.sv =====
// pjb_pkg: shared types, constants and helpers of the packet jitter buffer
// used by pjb_ctrl, pjb_store and packet_jitter_buffer_top; no dependencies
`timescale 1ns / 1ps

package pjb_pkg;

	localparam int DEPTH        = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int COUNT_W      = $clog2(DEPTH + 1);
	localparam int CFG_W        = 7;
	localparam int SEQ_W        = 32;
	localparam int TS_W         = 64;
	localparam int CNT_W        = 32;
	localparam int IDX_W        = 2;

	localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(64);
	localparam logic [CFG_W-1:0] PREFILL_RESET  = CFG_W'(4);

	typedef logic [PTR_W-1:0]        ptr_t;
	typedef logic [COUNT_W-1:0]      count_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CAPACITY = 2'd0,
		REG_PREFILL  = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [SEQ_W-1:0] seq;
		logic [TS_W-1:0]  ts;
		pay_t             pay;
	} item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [TS_W-1:0]  ts;
		pay_t             pay;
	} entry_t;

	// control from the sequencer to the packet memory
	typedef struct packed {
		logic   we;
		ptr_t   waddr;
		entry_t wentry;
		logic   rd;
		ptr_t   raddr_pop;
		ptr_t   raddr_head;
	} mem_req_t;

	// status of one step, registered with the result word
	typedef struct packed {
		logic   pop_valid;
		logic   nonempty;
		count_t fill;
		logic   nearly_full;
		logic   prefill_reached;
		cnt_t   received;
		cnt_t   lost;
		cnt_t   overflow;
		cnt_t   underflow;
	} status_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic cnt_t sat_add(input cnt_t c, input cnt_t v);
		logic [CNT_W:0] s;
		s = {1'b0, c} + {1'b0, v};
		sat_add = s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/pjb_store.sv =====
// pjb_store: packet memory with one write port and two registered read ports
// depends on pjb_pkg
`timescale 1ns / 1ps

module pjb_store (
	input  logic              clk,
	input  pjb_pkg::mem_req_t req,
	output pjb_pkg::entry_t   pop_entry_s2,
	output logic [63:0]       head_ts_s2
);
	import pjb_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wentry;
		end
	end

	// head read forwards the word being written to the same slot
	always_ff @(posedge clk) begin
		if (req.rd) begin
			pop_entry_s2 <= mem[req.raddr_pop];
			if (req.we && (req.raddr_head == req.waddr)) begin
				head_ts_s2 <= req.wentry.ts;
			end else begin
				head_ts_s2 <= mem[req.raddr_head].ts;
			end
		end
	end

endmodule

// ===== rtl/core/pjb_ctrl.sv =====
// pjb_ctrl: fifo pointers, fill count, sequence tracking, event counters and config
// depends on pjb_pkg
`timescale 1ns / 1ps

module pjb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                step,
	input  pjb_pkg::item_t      item_s1,
	output pjb_pkg::mem_req_t   req,
	output pjb_pkg::status_t    status
);
	import pjb_pkg::*;

	localparam int CMP_W = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
	localparam int NF_W  = COUNT_W + 3;

	logic [CFG_W-1:0] capacity_q, prefill_q;
	ptr_t             head_q, tail_q, head_n, tail_n;
	count_t           count_q, count_n, cap_eff;
	logic [SEQ_W-1:0] newest_q, newest_n;
	logic             seen_q, seen_n;
	cnt_t             rx_q, lost_q, ovf_q, udf_q;
	cnt_t             rx_n, lost_n, ovf_n, udf_n;
	logic             pop_ok, drop;
	logic [SEQ_W:0]   newest_p1;
	logic [SEQ_W-1:0] gap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			prefill_q  <= PREFILL_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_PREFILL:  prefill_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capacity of zero acts as one, above the store depth acts as the depth
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = count_t'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			cap_eff = count_t'(DEPTH);
		end else begin
			cap_eff = count_t'(capacity_q);
		end
	end

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		count_n   = count_q;
		newest_n  = newest_q;
		seen_n    = seen_q;
		rx_n      = rx_q;
		lost_n    = lost_q;
		ovf_n     = ovf_q;
		udf_n     = udf_q;
		pop_ok    = 1'b0;
		drop      = 1'b0;
		newest_p1 = {1'b0, newest_q} + (SEQ_W + 1)'(1);
		gap       = item_s1.seq - newest_q - SEQ_W'(1);
		case (item_s1.kind)
			KIND_PUSH: begin
				rx_n = sat_add(rx_q, cnt_t'(1));
				if (seen_q && ({1'b0, item_s1.seq} > newest_p1)) begin
					lost_n = sat_add(lost_q, gap);
				end
				if (!seen_q || (item_s1.seq > newest_q)) begin
					newest_n = item_s1.seq;
					seen_n   = 1'b1;
				end
				// full: oldest packet goes out before the new one comes in
				drop = (count_q >= cap_eff) && (count_q != '0);
				if (drop) begin
					head_n = next_ptr(head_q);
					ovf_n  = sat_add(ovf_q, cnt_t'(1));
				end
				tail_n  = next_ptr(tail_q);
				count_n = count_q - count_t'(drop) + count_t'(1);
			end
			KIND_POP: begin
				if (count_q == '0) begin
					udf_n = sat_add(udf_q, cnt_t'(1));
				end else begin
					pop_ok  = 1'b1;
					head_n  = next_ptr(head_q);
					count_n = count_q - count_t'(1);
				end
			end
			KIND_CLEAR: begin
				head_n   = '0;
				tail_n   = '0;
				count_n  = '0;
				newest_n = '0;
				seen_n   = 1'b0;
				rx_n     = '0;
				lost_n   = '0;
				ovf_n    = '0;
				udf_n    = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			newest_q <= '0;
			seen_q   <= 1'b0;
			rx_q     <= '0;
			lost_q   <= '0;
			ovf_q    <= '0;
			udf_q    <= '0;
		end else if (step) begin
			head_q   <= head_n;
			tail_q   <= tail_n;
			count_q  <= count_n;
			newest_q <= newest_n;
			seen_q   <= seen_n;
			rx_q     <= rx_n;
			lost_q   <= lost_n;
			ovf_q    <= ovf_n;
			udf_q    <= udf_n;
		end
	end

	always_comb begin
		req.we         = step && (item_s1.kind == KIND_PUSH);
		req.waddr      = tail_q;
		req.wentry.seq = item_s1.seq;
		req.wentry.ts  = item_s1.ts;
		req.wentry.pay = item_s1.pay;
		req.rd         = step;
		req.raddr_pop  = head_q;
		req.raddr_head = head_n;
	end

	always_comb begin
		status.pop_valid       = pop_ok;
		status.nonempty        = (count_n != '0);
		status.fill            = count_n;
		status.nearly_full     = (NF_W'(count_n) * NF_W'(5)) >= (NF_W'(cap_eff) * NF_W'(4));
		status.prefill_reached = CMP_W'(count_n) >= CMP_W'(prefill_q);
		status.received        = rx_n;
		status.lost            = lost_n;
		status.overflow        = ovf_n;
		status.underflow       = udf_n;
	end

endmodule

// ===== rtl/core/packet_jitter_buffer_top.sv =====
// packet_jitter_buffer_top: top level of the packet jitter buffer
// depends on pjb_pkg, pjb_ctrl and pjb_store
`timescale 1ns / 1ps

// Bounded packet fifo for audio with drop-oldest overflow. Each input word is
// a command: push a packet, pop the head packet, or clear the fifo together
// with its counters and sequence tracking; every command gives exactly one
// result word with the popped packet (zeros when nothing was popped), the
// head timestamp, fill level, nearly-full and prefill flags and four
// saturating counters. One command is taken every clock cycle while the
// result register is free or its word is taken. A command sits in the input
// register while the pointers, counters and both packet memory reads are
// worked out, and all of them are registered together into the result
// register. An input register and a result register part the two sides, so
// a command is still taken while a finished result waits if the input
// register is empty. There is no clearing pass after reset. The user must
// write configuration (capacity, prefill level) through cfg_we only while no
// command is in flight; the block itself does not enforce this.
module packet_jitter_buffer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] sequence_req,
	input  logic [63:0] timestamp,
	input  logic [31:0] payload,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pop_valid,
	output logic [31:0] out_sequence,
	output logic [63:0] out_timestamp,
	output logic [31:0] out_payload,
	output logic [63:0] head_timestamp,
	output logic [6:0]  fill_level,
	output logic        nearly_full,
	output logic        prefill_reached,
	output logic [31:0] received_count,
	output logic [31:0] lost_count,
	output logic [31:0] overflow_drops,
	output logic [31:0] underflow_count
);
	import pjb_pkg::*;

	logic     valid_s1, valid_s2;
	item_t    item_s1;
	logic     advance, step, in_take;
	mem_req_t req;
	status_t  status, status_s2;
	entry_t   pop_entry_s2;
	logic [TS_W-1:0] head_ts_s2;

	// result register frees up when empty or when its word is taken
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// command payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind <= kind;
			item_s1.seq  <= sequence_req;
			item_s1.ts   <= timestamp;
			item_s1.pay  <= pay_t'(payload);
		end
	end

	pjb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.item_s1   (item_s1),
		.req       (req),
		.status    (status)
	);

	pjb_store u_store (
		.clk          (clk),
		.req          (req),
		.pop_entry_s2 (pop_entry_s2),
		.head_ts_s2   (head_ts_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_s2 <= status;
		end
	end

	assign out_valid = valid_s2;

	// packet fields read as zero when nothing was popped or the fifo is empty
	assign pop_valid       = status_s2.pop_valid;
	assign out_sequence    = status_s2.pop_valid ? pop_entry_s2.seq : '0;
	assign out_timestamp   = status_s2.pop_valid ? pop_entry_s2.ts : '0;
	assign out_payload     = status_s2.pop_valid ? 32'(pop_entry_s2.pay) : '0;
	assign head_timestamp  = status_s2.nonempty ? head_ts_s2 : '0;
	assign fill_level      = 7'(status_s2.fill);
	assign nearly_full     = status_s2.nearly_full;
	assign prefill_reached = status_s2.prefill_reached;
	assign received_count  = status_s2.received;
	assign lost_count      = status_s2.lost;
	assign overflow_drops  = status_s2.overflow;
	assign underflow_count = status_s2.underflow;

endmodule
